// ===== sv/keyed_list_add_find_remove_macros.svh =====
// ----------------------------------------------------------------------------
// keyed list assertion macros
// shared concurrent assertion forms for the keyed list checker
// ----------------------------------------------------------------------------
`ifndef KEYED_LIST_ADD_FIND_REMOVE_MACROS_SVH
`define KEYED_LIST_ADD_FIND_REMOVE_MACROS_SVH

// same-cycle implication
`define KLAFR_AST_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyed list check failed");

// next-cycle implication
`define KLAFR_AST_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyed list check failed");

`endif

// ===== sv/klafr_pkg.sv =====
// ----------------------------------------------------------------------------
// klafr_pkg
// types, constants and string clipping functions of the keyed list
// ----------------------------------------------------------------------------
package klafr_pkg;

   localparam int KEY_PORT_W      = 64;
   localparam int NAME_PORT_BYTES = 20;
   localparam int NAME_PORT_W     = NAME_PORT_BYTES * 8;
   localparam int POS_W           = 4;
   localparam int CNT_PORT_W      = 5;
   localparam int RIDX_W          = 4;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_FIND   = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RDWAIT,
      S_SCAN,
      S_SHIFT
   } fsm_type;

   typedef struct packed {
      op_type                  op;
      logic [KEY_PORT_W-1:0]   key;
      logic [NAME_PORT_W-1:0]  name;
      logic [RIDX_W-1:0]       read_index;
   } request_type;

   typedef struct packed {
      status_type              status;
      logic [POS_W-1:0]        position;
      logic [KEY_PORT_W-1:0]   key;
      logic [NAME_PORT_W-1:0]  name;
      logic [CNT_PORT_W-1:0]   count;
   } result_type;

   // keep bytes up to the first zero byte and below limit
   function automatic logic [KEY_PORT_W-1:0] clip_key(input logic [KEY_PORT_W-1:0] raw,
                                                      input int unsigned limit);
      logic                  alive;
      logic [KEY_PORT_W-1:0] res;
      alive = 1'b1;
      res   = '0;
      for (int unsigned i = 0; i < KEY_PORT_W / 8; i++) begin
         alive = alive & (raw[8*i +: 8] != 8'd0) & (i < limit);
         if (alive) begin
            res[8*i +: 8] = raw[8*i +: 8];
         end
      end
      return res;
   endfunction

   function automatic logic [NAME_PORT_W-1:0] clip_name(input logic [NAME_PORT_W-1:0] raw,
                                                        input int unsigned limit);
      logic                   alive;
      logic [NAME_PORT_W-1:0] res;
      alive = 1'b1;
      res   = '0;
      for (int unsigned i = 0; i < NAME_PORT_BYTES; i++) begin
         alive = alive & (raw[8*i +: 8] != 8'd0) & (i < limit);
         if (alive) begin
            res[8*i +: 8] = raw[8*i +: 8];
         end
      end
      return res;
   endfunction

endpackage

// ===== sv/klafr_ram.sv =====
// ----------------------------------------------------------------------------
// klafr_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module klafr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/klafr_engine.sv =====
// ----------------------------------------------------------------------------
// klafr_engine
// list sequencer: append, linear search, gap closing shift and indexed read
// over one entry memory
// ----------------------------------------------------------------------------
module klafr_engine
   import klafr_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int KEY_BYTES  = 8,
   parameter int NAME_BYTES = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  request_type req_i,
   output logic        busy,
   output logic        rsp_valid,
   output result_type  rsp_o
);

   localparam int AW        = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int IXW       = CNT_W + 1;
   localparam int RW        = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
   localparam int KEY_W     = KEY_BYTES * 8;
   localparam int NAME_KEEP = (NAME_BYTES > NAME_PORT_BYTES) ? NAME_PORT_BYTES : NAME_BYTES;
   localparam int NAME_W    = NAME_KEEP * 8;
   localparam int MEM_W     = KEY_W + NAME_W;

   fsm_type          state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [AW-1:0]    pos_ff, pos_in;
   request_type      req_ff, req_in;
   result_type       rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [MEM_W-1:0] wr_data;
   logic [AW-1:0]    rd_addr;
   logic [MEM_W-1:0] rd_data;

   logic             accept;
   logic             rd_ok;
   logic             key_hit;
   logic             more_scan;
   logic             more_shift;
   result_type       rsp_base;

   klafr_ram #(
      .WIDTH (MEM_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy       = (state_ff != S_IDLE);
   assign accept     = start && !busy;
   assign rd_ok      = RW'(req_i.read_index) < RW'(count_ff);
   assign key_hit    = (rd_data[MEM_W-1 -: KEY_W] == KEY_W'(req_ff.key));
   assign more_scan  = (IXW'(idx_ff) + IXW'(1)) < IXW'(count_ff);
   assign more_shift = (IXW'(idx_ff) + IXW'(2)) < IXW'(count_ff);
   assign rsp_base   = '{status: ST_OK, position: '0, key: '0, name: '0,
                         count: CNT_PORT_W'(count_ff)};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_i.op)
                  OP_ADD: state_in = S_IDLE;
                  OP_READ: begin
                     if (rd_ok) state_in = S_RDWAIT;
                  end
                  OP_REMOVE, OP_FIND: begin
                     if (count_ff != '0) state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_RDWAIT: state_in = S_IDLE;
         S_SCAN: begin
            if (key_hit) begin
               state_in = (req_ff.op == OP_REMOVE && more_scan) ? S_SHIFT : S_IDLE;
            end else if (!more_scan) begin
               state_in = S_IDLE;
            end
         end
         S_SHIFT: begin
            if (!more_shift) state_in = S_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;
      rd_addr      = AW'(IXW'(idx_ff) + IXW'(1));
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_i;
               idx_in = '0;
               rsp_in = rsp_base;
               unique case (req_i.op)
                  OP_ADD: begin
                     rsp_valid_in = 1'b1;
                     if (IXW'(count_ff) == IXW'(DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        wr_en           = 1'b1;
                        wr_addr         = AW'(count_ff);
                        wr_data         = {KEY_W'(req_i.key), NAME_W'(req_i.name)};
                        count_in        = count_ff + CNT_W'(1);
                        rsp_in.position = POS_W'(count_ff);
                        rsp_in.count    = CNT_PORT_W'(count_ff + CNT_W'(1));
                     end
                  end
                  OP_READ: begin
                     rd_addr = AW'(req_i.read_index);
                     if (!rd_ok) begin
                        rsp_in.status = ST_RANGE;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  OP_REMOVE, OP_FIND: begin
                     rd_addr = '0;
                     if (count_ff == '0) begin
                        rsp_in.status = ST_NOT_FOUND;
                        rsp_valid_in  = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_RDWAIT: begin
            rsp_in          = rsp_base;
            rsp_in.position = POS_W'(req_ff.read_index);
            rsp_in.key      = KEY_PORT_W'(rd_data[MEM_W-1 -: KEY_W]);
            rsp_in.name     = NAME_PORT_W'(rd_data[NAME_W-1:0]);
            rsp_valid_in    = 1'b1;
         end
         S_SCAN: begin
            rsp_in = rsp_base;
            if (key_hit) begin
               pos_in = idx_ff;
               if (req_ff.op == OP_REMOVE && more_scan) begin
                  idx_in = idx_ff;
               end else begin
                  rsp_in.position = POS_W'(idx_ff);
                  rsp_valid_in    = 1'b1;
                  if (req_ff.op == OP_REMOVE) begin
                     count_in     = count_ff - CNT_W'(1);
                     rsp_in.count = CNT_PORT_W'(count_ff - CNT_W'(1));
                  end
               end
            end else if (more_scan) begin
               idx_in = AW'(IXW'(idx_ff) + IXW'(1));
            end else begin
               rsp_in.status = ST_NOT_FOUND;
               rsp_valid_in  = 1'b1;
            end
         end
         S_SHIFT: begin
            // entry idx+1 arrives, lands one place down
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = rd_data;
            rsp_in  = rsp_base;
            if (more_shift) begin
               idx_in  = AW'(IXW'(idx_ff) + IXW'(1));
               rd_addr = AW'(IXW'(idx_ff) + IXW'(2));
            end else begin
               count_in        = count_ff - CNT_W'(1);
               rsp_in.position = POS_W'(pos_ff);
               rsp_in.count    = CNT_PORT_W'(count_ff - CNT_W'(1));
               rsp_valid_in    = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_o     = rsp_ff;

endmodule

// ===== sv/keyed_list_add_find_remove.sv =====
// ----------------------------------------------------------------------------
// keyed_list_add_find_remove
// ordered keyed list with add, remove by key, find by key and indexed read
//
// channel   ports                      transfer
// request   start, busy, req_*         rising edge with start high, busy low
// result    rsp_valid, rsp_*           every cycle rsp_valid is high
//
// add, list full, read beyond count and find or remove on an empty list:
// result in the cycle after the request transfer
// read: the result is registered after the registered memory read and the read wait state
// find and remove search the entries in order, and a remove hit then shifts the
// later entries one place down, both through the single memory read port (one
// entry per cycle for search and shift)
// reset clears the state, the count and rsp_valid; the entry memory needs no clearing pass
// results cannot be stalled; a new request may be taken while one is shown
// ----------------------------------------------------------------------------
module keyed_list_add_find_remove
   import klafr_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int KEY_BYTES  = 8,
   parameter int NAME_BYTES = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [1:0]   req_type,
   input  logic [63:0]  req_key,
   input  logic [63:0]  req_name_part0,
   input  logic [63:0]  req_name_part1,
   input  logic [31:0]  req_name_part2,
   input  logic [3:0]   req_read_index,
   output logic         rsp_valid,
   output logic [1:0]   rsp_status,
   output logic [3:0]   rsp_position,
   output logic [63:0]  rsp_entry_key,
   output logic [63:0]  rsp_entry_name0,
   output logic [63:0]  rsp_entry_name1,
   output logic [31:0]  rsp_entry_name2,
   output logic [4:0]   rsp_count_after
);

   request_type req;
   result_type  rsp;

   // zero padded string form of key and name
   always_comb begin
      req.op         = op_type'(req_type);
      req.key        = clip_key(req_key, KEY_BYTES);
      req.name       = clip_name({req_name_part2, req_name_part1, req_name_part0},
                                 NAME_BYTES);
      req.read_index = req_read_index;
   end

   klafr_engine #(
      .DEPTH      (DEPTH),
      .KEY_BYTES  (KEY_BYTES),
      .NAME_BYTES (NAME_BYTES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_i     (req),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_o     (rsp)
   );

   assign rsp_status      = rsp.status;
   assign rsp_position    = rsp.position;
   assign rsp_entry_key   = rsp.key;
   assign rsp_entry_name0 = rsp.name[63:0];
   assign rsp_entry_name1 = rsp.name[127:64];
   assign rsp_entry_name2 = rsp.name[159:128];
   assign rsp_count_after = rsp.count;

endmodule

// ===== sv/klafr_check.sv =====
// ----------------------------------------------------------------------------
// klafr_check
// port level checks of the keyed list, bound to the top level
// ----------------------------------------------------------------------------
`include "keyed_list_add_find_remove_macros.svh"

module klafr_check
   import klafr_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input logic [1:0]   rsp_status,
   input logic [3:0]   rsp_position,
   input logic [4:0]   rsp_count_after
);

   // a result always ends the work of its request
   `KLAFR_AST_IMP(a_rsp_not_busy, clock, reset, rsp_valid, !busy)

   // work starts only from a request transfer
   `KLAFR_AST_IMP(a_busy_from_start, clock, reset, $rose(busy), $past(start))

   // failed requests report position zero
   `KLAFR_AST_IMP(a_fail_pos_zero, clock, reset,
      rsp_valid && rsp_status != ST_OK, rsp_position == 4'd0)

   // full is reported only with the list at capacity
   `KLAFR_AST_IMP(a_full_count, clock, reset,
      rsp_valid && rsp_status == ST_FULL, rsp_count_after == 5'(DEPTH))

endmodule

bind keyed_list_add_find_remove klafr_check #(.DEPTH(DEPTH)) u_klafr_check (.*);
